>>> sv/multilevel_priority_task_picker_defines.svh
// Assertion macros for the task picker checker.
`ifndef MULTILEVEL_PRIORITY_TASK_PICKER_DEFINES_SVH
`define MULTILEVEL_PRIORITY_TASK_PICKER_DEFINES_SVH
// Assert an implication on every clock edge outside reset.
`define MPTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert an implication in the next cycle.
`define MPTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/mptp_pkg.sv
// Package: constants, codes and types of the task picker.
package mptp_pkg;
  localparam int SLOTS = 64;
  localparam int SW = $clog2(SLOTS);
  localparam int GROUP_WIDTH = 16;
  // Entry layout: state(3) prio(3) level(2) group.
  localparam int EW = 8 + GROUP_WIDTH;

  localparam logic [2:0] CMD_PICK = 3'd0;
  localparam logic [2:0] CMD_ALLOC = 3'd1;
  localparam logic [2:0] CMD_STATE = 3'd2;
  localparam logic [2:0] CMD_PRIO = 3'd3;
  localparam logic [2:0] CMD_LEVEL = 3'd4;

  localparam logic [2:0] ST_UNUSED = 3'd0;
  localparam logic [2:0] ST_EMBRYO = 3'd1;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING = 3'd4;

  // Policy modes; anything above MODE_QUEUES is not a valid mode.
  localparam logic [2:0] MODE_LOW_FIRST = 3'd2;
  localparam logic [2:0] MODE_HIGH_FIRST = 3'd3;
  localparam logic [2:0] MODE_QUEUES = 3'd4;

  typedef struct packed {
    logic [2:0] st;
    logic [2:0] prio;
    logic [1:0] lvl;
    logic [GROUP_WIDTH-1:0] grp;
  } entry_t;

  // Candidate cand ranks strictly better than current cur.
  function automatic logic prio_better(entry_t cur, entry_t cand, logic low_first);
    if (cur.prio != cand.prio) return low_first ? (cur.prio > cand.prio)
                                                : (cur.prio < cand.prio);
    return cur.grp > cand.grp;
  endfunction

  function automatic logic ranks_better(entry_t cur, entry_t cand, logic [2:0] mode);
    if (mode == MODE_LOW_FIRST) return prio_better(cur, cand, 1'b1);
    if (mode == MODE_HIGH_FIRST) return prio_better(cur, cand, 1'b0);
    if (cur.lvl != cand.lvl) return cur.lvl > cand.lvl;
    if (cur.lvl < 2'd2) return cur.grp > cand.grp;
    if (cur.lvl == 2'd2) return prio_better(cur, cand, 1'b1);
    return prio_better(cur, cand, 1'b0);
  endfunction
endpackage

>>> sv/mptp_ram.sv
// Generic single-port synchronous RAM with registered read.
module mptp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> sv/multilevel_priority_task_picker.sv
// Top level: command-driven multilevel priority task picker.
// Usage:
//  - Raise start with cmd, slot_index and value while busy is low; the command
//    transfers at that edge and busy rises on the next cycle.
//  - One result per command appears for exactly one cycle with done high:
//    ok, chosen_slot, task_id. The receiver cannot stall; take it then.
//    busy drops in the cycle after done, so the next command may follow then.
//  - The task table lives in one 64-entry RAM, one slot per word.
//  - Reset runs a clearing pass over all SLOTS words of the RAM; busy stays high
//    meanwhile. policy_mode may be written (cfg_valid/cfg_ready) while the
//    block is idle and start is low; values 5..7 are dropped.
//  - Set commands: the slot is read, then written back, before done.
//  - Allocate: scans from slot 0, one RAM read a cycle.
//  - Pick: scans SLOTS slots from scan_pointer for the start slot, then under
//    policies 2..4 a second full sweep from slot 0 ranks candidates. The single
//    RAM read port means one slot is examined per cycle.
module multilevel_priority_task_picker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [5:0]  slot_index,
  input  logic [2:0]  value,
  output logic        done,
  output logic        ok,
  output logic [5:0]  chosen_slot,
  output logic [15:0] task_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  localparam int SW = mptp_pkg::SW;
  localparam int SLOTS = mptp_pkg::SLOTS;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SET   = 7'b0000100,
    S_SCAN1 = 7'b0001000,
    S_SCAN2 = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state;
  logic [2:0] policy_mode;
  logic [SW-1:0] scan_pointer;
  logic [15:0] next_id;
  logic [2:0] cmd_r, val_r;
  logic [SW-1:0] slot_r;
  // Scan: addr issued, count issued, read-back slot tracking
  logic [SW-1:0] addr;
  logic [SW:0] cnt;          // reads issued in this sweep
  logic rd_vld;              // rdata belongs to rd_slot this cycle
  logic [SW-1:0] rd_slot;
  logic [SW-1:0] pick;
  mptp_pkg::entry_t pick_e;

  logic we;
  logic [SW-1:0] ram_addr;
  mptp_pkg::entry_t wdata, rdata;

  mptp_ram #(.WIDTH(mptp_pkg::EW), .DEPTH(SLOTS)) u_table (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
  );

  logic rd_hit;
  assign rd_hit = rd_vld && (rdata.st == mptp_pkg::ST_RUNNABLE);
  logic ranked;
  assign ranked = (policy_mode >= mptp_pkg::MODE_LOW_FIRST) &&
                  (policy_mode <= mptp_pkg::MODE_QUEUES);
  assign busy = (state != S_IDLE);
  // Take a policy write only between commands, never beside a new one.
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    we = 1'b0;
    ram_addr = addr;
    wdata = rdata;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
      end
      S_SET: begin
        ram_addr = slot_r;
        if (rd_vld) begin
          we = 1'b1;
          if (cmd_r == mptp_pkg::CMD_STATE) wdata.st = val_r;
          else if (cmd_r == mptp_pkg::CMD_PRIO)
            wdata.prio = (val_r >= 3'd1 && val_r <= 3'd6) ? val_r : 3'd5;
          else if (val_r <= 3'd3) wdata.lvl = val_r[1:0];
        end
      end
      S_FIN: begin
        ram_addr = pick;
        we = 1'b1;
        wdata = pick_e;
        if (cmd_r == mptp_pkg::CMD_ALLOC) begin
          // Fresh task: embryo, middle priority, lowest queue, no groups.
          wdata.st = mptp_pkg::ST_EMBRYO;
          wdata.prio = 3'd3;
          wdata.lvl = 2'd3;
          wdata.grp = '0;
        end else begin
          wdata.st = mptp_pkg::ST_RUNNING;
          if (ranked && pick_e.grp != '1) wdata.grp = pick_e.grp + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (cfg_valid && cfg_ready && cfg_data <= mptp_pkg::MODE_QUEUES) policy_mode <= cfg_data;
    if (rst) begin
      state <= S_CLEAR;
      addr <= '0;
      policy_mode <= '0;
      scan_pointer <= '0;
      next_id <= 16'd1;
      done <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == SW'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          rd_vld <= 1'b0;
          if (start) begin
            cmd_r <= cmd; slot_r <= slot_index; val_r <= value;
            cnt <= '0;
            // Pick scans from scan_pointer; allocate from slot 0.
            addr <= (cmd == mptp_pkg::CMD_PICK) ? scan_pointer : '0;
            if (cmd == mptp_pkg::CMD_PICK || cmd == mptp_pkg::CMD_ALLOC) state <= S_SCAN1;
            else if (cmd == mptp_pkg::CMD_STATE || cmd == mptp_pkg::CMD_PRIO ||
                     cmd == mptp_pkg::CMD_LEVEL) state <= S_SET;
            else begin
              done <= 1'b1; ok <= 1'b0; chosen_slot <= '0; task_id <= '0;
              state <= S_WAIT;
            end
          end
        end
        S_SET: begin
          rd_vld <= 1'b1;
          if (rd_vld) begin
            rd_vld <= 1'b0;
            done <= 1'b1; ok <= 1'b1; chosen_slot <= '0; task_id <= '0;
            state <= S_WAIT;
          end
        end
        S_SCAN1: begin
          // Issue a read each cycle; examine the previous read's data.
          if (cnt != (SW+1)'(SLOTS)) begin
            addr <= addr + 1'b1;
            cnt <= cnt + 1'b1;
            rd_vld <= 1'b1;
            rd_slot <= addr;
          end else rd_vld <= 1'b0;
          if (cmd_r == mptp_pkg::CMD_ALLOC && rd_vld &&
              rdata.st == mptp_pkg::ST_UNUSED) begin
            // Claim this slot; S_FIN writes the fresh entry.
            pick <= rd_slot;
            pick_e <= rdata;
            rd_vld <= 1'b0;
            state <= S_FIN;
          end else if (cmd_r == mptp_pkg::CMD_PICK && rd_hit) begin
            pick <= rd_slot;
            pick_e <= rdata;
            rd_vld <= 1'b0;
            if (ranked) begin
              addr <= '0; cnt <= '0; state <= S_SCAN2;
            end else state <= S_FIN;
          end else if (!rd_vld && cnt == (SW+1)'(SLOTS)) begin
            done <= 1'b1; ok <= 1'b0; chosen_slot <= '0; task_id <= '0;
            state <= S_WAIT;
          end
        end
        S_SCAN2: begin
          if (cnt != (SW+1)'(SLOTS)) begin
            addr <= addr + 1'b1;
            cnt <= cnt + 1'b1;
            rd_vld <= 1'b1;
            rd_slot <= addr;
          end else rd_vld <= 1'b0;
          if (rd_hit && mptp_pkg::ranks_better(pick_e, rdata, policy_mode)) begin
            pick <= rd_slot;
            pick_e <= rdata;
          end
          if (!rd_vld && cnt == (SW+1)'(SLOTS)) state <= S_FIN;
        end
        S_FIN: begin
          done <= 1'b1; ok <= 1'b1; chosen_slot <= 6'(pick);
          if (cmd_r == mptp_pkg::CMD_ALLOC) begin
            task_id <= next_id;
            next_id <= next_id + 1'b1;
          end else begin
            task_id <= '0;
            scan_pointer <= pick + 1'b1;
          end
          state <= S_WAIT;
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/mptp_checker.sv
// Port-level checker for the task picker, bound to the top level.
`include "multilevel_priority_task_picker_defines.svh"
module mptp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        ok,
  input logic [5:0]  chosen_slot,
  input logic [15:0] task_id
);
  `MPTP_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `MPTP_ASSERT_IMP(a_done_busy, done, busy)
  `MPTP_ASSERT_IMP(a_fail_zero, done && !ok, chosen_slot == 6'd0 && task_id == 16'd0)
  `MPTP_ASSERT_NXT(a_done_single, done, !done)
endmodule

bind multilevel_priority_task_picker mptp_checker u_mptp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .ok(ok), .chosen_slot(chosen_slot), .task_id(task_id)
);
